@@ src/frhp_pkg.sv @@
// ----------------------------------------------------------------------------
// frhp_pkg
// Shared types, character codes and scan helpers for the record header parser.
// ----------------------------------------------------------------------------
package frhp_pkg;

    // accumulator width; numbers wrap modulo 2^SIZE_BITS (range 16..64)
    localparam int SIZE_BITS = 32;
    localparam int EXT_BITS  = (SIZE_BITS > 32) ? SIZE_BITS : 32;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UO    = 8'h4F;
    localparam logic [7:0] CH_UT    = 8'h54;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [4:0] RADIX_OCT  = 5'd8;
    localparam logic [4:0] RADIX_DEC  = 5'd10;
    localparam logic [4:0] RADIX_HEX  = 5'd16;
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    typedef enum logic [4:0] {
        ST_CMD   = 5'b00001,
        ST_MODE  = 5'b00010,
        ST_SIZE  = 5'b00100,
        ST_NLEAD = 5'b01000,
        ST_NAME  = 5'b10000
    } stage_t;

    typedef enum logic [5:0] {
        SUB_LEAD = 6'b000001,
        SUB_ZERO = 6'b000010,
        SUB_X    = 6'b000100,
        SUB_O    = 6'b001000,
        SUB_T    = 6'b010000,
        SUB_DIG  = 6'b100000
    } sub_t;

    typedef struct packed {
        sub_t       sub;
        logic       neg;
        logic [4:0] radix;
        logic       take;   // byte is a digit of the number
        logic       ended;  // byte terminates the number, handled by next stage
        logic [3:0] digit;
    } scan_t;

    typedef struct packed {
        logic               name_valid;
        logic [7:0]         name_byte;
        logic               record_done;
        logic               record_error;
        logic [7:0]         command;
        logic signed [15:0] mode_value;
        logic signed [31:0] size_value;
    } result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) || (b == CH_CR) ||
               (b == CH_SPACE);
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] b);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (b >= CH_ZERO && b <= CH_NINE)
            d = 5'(b - CH_ZERO);
        else if (b >= CH_LA && b <= CH_LF)
            d = 5'(b - CH_LA + 8'd10);
        else if (b >= CH_UA && b <= CH_UF)
            d = 5'(b - CH_UA + 8'd10);
        return d;
    endfunction

    // One byte through the number syntax; sign, '0', then x/o/t, then digits.
    // Sub-states only fall forward, so one ordered pass covers every retry.
    function automatic scan_t num_scan(input sub_t sub, input logic neg,
                                       input logic [4:0] radix, input logic [7:0] b);
        scan_t      r;
        logic       done;
        logic [4:0] d;
        r       = '0;
        r.sub   = sub;
        r.neg   = neg;
        r.radix = radix;
        done    = 1'b0;
        d       = digit_of(b);
        if (r.sub == SUB_LEAD) begin
            if (is_ws(b)) begin
                done = 1'b1;
            end
            else begin
                r.sub = SUB_ZERO;
                if (b == CH_MINUS) begin
                    r.neg = 1'b1;
                    done  = 1'b1;
                end
                else if (b == CH_PLUS) begin
                    done = 1'b1;
                end
            end
        end
        if (!done && r.sub == SUB_ZERO) begin
            if (b == CH_ZERO) begin
                r.sub = SUB_X;
                done  = 1'b1;
            end
            else begin
                r.sub = SUB_DIG;
            end
        end
        if (!done && r.sub == SUB_X) begin
            r.sub = SUB_O;
            if (b == CH_LX || b == CH_UX) begin
                r.radix = RADIX_HEX;
                done    = 1'b1;
            end
        end
        if (!done && r.sub == SUB_O) begin
            r.sub = SUB_T;
            if (b == CH_LO || b == CH_UO) begin
                r.radix = RADIX_OCT;
                done    = 1'b1;
            end
        end
        if (!done && r.sub == SUB_T) begin
            r.sub = SUB_DIG;
            if (b == CH_LT || b == CH_UT) begin
                r.radix = RADIX_DEC;
                done    = 1'b1;
            end
        end
        if (!done && r.sub == SUB_DIG) begin
            if (d < r.radix) begin
                r.take  = 1'b1;
                r.digit = d[3:0];
            end
            else begin
                r.ended = 1'b1;
            end
        end
        return r;
    endfunction

    // acc * radix + digit by shifts and adds
    function automatic logic [SIZE_BITS-1:0] acc_step(input logic [SIZE_BITS-1:0] acc,
                                                      input logic [4:0] radix,
                                                      input logic [3:0] digit);
        logic [SIZE_BITS-1:0] r;
        case (radix)
            RADIX_HEX: r = (acc << 4) + SIZE_BITS'(digit);
            RADIX_DEC: r = (acc << 3) + (acc << 1) + SIZE_BITS'(digit);
            default:   r = (acc << 3) + SIZE_BITS'(digit);
        endcase
        return r;
    endfunction

    function automatic logic [EXT_BITS-1:0] signed_ext(input logic [SIZE_BITS-1:0] acc,
                                                       input logic neg);
        logic [SIZE_BITS-1:0] v;
        v = neg ? (~acc + 1'b1) : acc;
        return EXT_BITS'(signed'(v));
    endfunction

endpackage

@@ src/frhp_parse_core.sv @@
// ----------------------------------------------------------------------------
// frhp_parse_core
// Parser state and per-byte next-state / result logic.
// ----------------------------------------------------------------------------
module frhp_parse_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       in_byte,
    output frhp_pkg::result_t res
);
    import frhp_pkg::*;

    stage_t               stage_reg, stage_next;
    sub_t                 sub_reg, sub_next;
    logic                 neg_reg, neg_next;
    logic [4:0]           radix_reg, radix_next;
    logic [SIZE_BITS-1:0] acc_reg, acc_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic [15:0]          mode_reg, mode_next;

    scan_t                rm, rs;
    logic                 size_fresh;
    logic [SIZE_BITS-1:0] size_acc_in;
    logic [EXT_BITS-1:0]  cur_ext;
    logic                 is_end;
    logic                 run_size, run_name, name_lead;

    always_comb
    begin
        size_fresh  = (stage_reg != ST_SIZE);
        size_acc_in = size_fresh ? '0 : acc_reg;
        rm          = num_scan(sub_reg, neg_reg, radix_reg, in_byte);
        rs          = num_scan(size_fresh ? SUB_LEAD : sub_reg,
                               size_fresh ? 1'b0 : neg_reg,
                               size_fresh ? RADIX_DEC : radix_reg, in_byte);
        cur_ext     = signed_ext(acc_reg, neg_reg);
        is_end      = (in_byte == CH_NL) || (in_byte == CH_NUL);

        stage_next = stage_reg;
        sub_next   = sub_reg;
        neg_next   = neg_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        cmd_next   = cmd_reg;
        mode_next  = mode_reg;
        run_size   = 1'b0;
        run_name   = 1'b0;
        name_lead  = 1'b0;
        res        = '0;

        if (is_end) begin
            res.record_done = 1'b1;
            if (stage_reg == ST_CMD) begin
                res.record_error = 1'b1;
            end
            else begin
                res.command    = cmd_reg;
                res.mode_value = (stage_reg == ST_MODE) ? cur_ext[15:0] : mode_reg;
                if (stage_reg == ST_SIZE || stage_reg == ST_NLEAD || stage_reg == ST_NAME)
                    res.size_value = cur_ext[31:0];
            end
            stage_next = ST_CMD;
            sub_next   = SUB_LEAD;
            neg_next   = 1'b0;
            radix_next = RADIX_OCT;
            acc_next   = '0;
            cmd_next   = '0;
            mode_next  = '0;
        end
        else begin
            case (stage_reg)
                ST_CMD:
                begin
                    cmd_next   = in_byte;
                    stage_next = ST_MODE;
                    sub_next   = SUB_LEAD;
                end
                ST_MODE:
                begin
                    sub_next   = rm.sub;
                    neg_next   = rm.neg;
                    radix_next = rm.radix;
                    if (rm.take)
                        acc_next = acc_step(acc_reg, rm.radix, rm.digit);
                    if (rm.ended) begin
                        mode_next = cur_ext[15:0];
                        run_size  = 1'b1;
                    end
                end
                ST_SIZE:
                begin
                    run_size = 1'b1;
                end
                ST_NLEAD:
                begin
                    run_name  = 1'b1;
                    name_lead = 1'b1;
                end
                default:
                begin
                    run_name = 1'b1;
                end
            endcase

            // continue the size number; the terminating byte of the mode falls into a fresh size number
            if (run_size) begin
                stage_next = ST_SIZE;
                sub_next   = rs.sub;
                neg_next   = rs.neg;
                radix_next = rs.radix;
                acc_next   = rs.take ? acc_step(size_acc_in, rs.radix, rs.digit)
                                     : size_acc_in;
                if (rs.ended) begin
                    run_name  = 1'b1;
                    name_lead = 1'b1;
                end
            end

            if (run_name) begin
                if (name_lead && is_ws(in_byte)) begin
                    stage_next = ST_NLEAD;
                end
                else begin
                    stage_next     = ST_NAME;
                    res.name_valid = 1'b1;
                    res.name_byte  = in_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_reg <= ST_CMD;
            sub_reg   <= SUB_LEAD;
            neg_reg   <= 1'b0;
            radix_reg <= RADIX_OCT;
            acc_reg   <= '0;
            cmd_reg   <= '0;
            mode_reg  <= '0;
        end
        else if (in_fire) begin
            stage_reg <= stage_next;
            sub_reg   <= sub_next;
            neg_reg   <= neg_next;
            radix_reg <= radix_next;
            acc_reg   <= acc_next;
            cmd_reg   <= cmd_next;
            mode_reg  <= mode_next;
        end
    end

    a_name_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        res.name_valid |-> !res.record_done)
        else $error("name byte reported on record end");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && res.record_done |=> stage_reg == ST_CMD && acc_reg == '0 && !neg_reg)
        else $error("state not cleared after record end");

    a_name_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && stage_reg == ST_NAME && !res.record_done |=> stage_reg == ST_NAME)
        else $error("left name stage without record end");

    a_radix_legal: assert property (@(posedge clk) disable iff (!rst_n)
        radix_reg == RADIX_OCT || radix_reg == RADIX_DEC || radix_reg == RADIX_HEX)
        else $error("illegal radix");

    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.record_error |-> res.command == '0 && res.size_value == '0)
        else $error("fields set on empty record");

endmodule

@@ src/frhp_out_stage.sv @@
// ----------------------------------------------------------------------------
// frhp_out_stage
// Result register; takes a new result whenever empty or being drained.
// ----------------------------------------------------------------------------
module frhp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  frhp_pkg::result_t res_in,
    output logic              ready,
    input  logic              out_ready,
    output logic              out_valid,
    output frhp_pkg::result_t res_out
);
    import frhp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign ready     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res_in;
    end

endmodule

@@ src/file_record_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// file_record_header_parser_unit
// Byte-wise parser of copy-protocol control record headers.
// ----------------------------------------------------------------------------
//  Channel  Dir  Content
//  s_axis   in   tdata[7:0] = record byte
//  m_axis   out  tdata = name_byte, command, mode_value, size_value;
//                tuser = name_valid, record_error; tlast = record_done
//
//  One result per input byte; one byte accepted per cycle while m_axis is not stalled.
//  Each result is registered and shows on m_axis in the cycle after its byte is
//  accepted: state update and result decode sit between the parser state registers and the result register.
//  Reset clears the parser to "expect command byte" and empties the result.
//  A stalled m_axis holds the result and lowers s_axis_tready.
// ----------------------------------------------------------------------------
module file_record_header_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] name_byte, [15:8] command,
                                        // [31:16] mode_value, [63:32] size_value
    output logic [1:0]  m_axis_tuser,   // [0] name_valid, [1] record_error
    output logic        m_axis_tlast    // record_done
);
    import frhp_pkg::*;

    logic    in_fire;
    result_t res;
    result_t res_q;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    frhp_parse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_byte (s_axis_tdata),
        .res     (res)
    );

    frhp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .res_in    (res),
        .ready     (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .res_out   (res_q)
    );

    assign m_axis_tdata = {res_q.size_value, res_q.mode_value, res_q.command, res_q.name_byte};
    assign m_axis_tuser = {res_q.record_error, res_q.name_valid};
    assign m_axis_tlast = res_q.record_done;

endmodule
